[rtl/pcxrle_pkg.sv]
// shared types and constants of the pcx run-length scanline decoder
package pcxrle_pkg;

   localparam logic [7:0] RUN_MARK = 8'hC0;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [1:0] CSR_BYTES_PER_LINE = 2'd0;
   localparam logic [1:0] CSR_PLANE_COUNT    = 2'd1;
   localparam logic [1:0] CSR_ROW_COUNT      = 2'd2;

   localparam logic [15:0] BYTES_PER_LINE_RESET = 16'd320;
   localparam logic [2:0]  PLANE_COUNT_RESET    = 3'd1;
   localparam logic [15:0] ROW_COUNT_RESET      = 16'd200;

   typedef struct packed {
      logic [7:0] value;
      logic [5:0] count;
   } run_cmd_type;

   typedef struct packed {
      logic [15:0] bytes_per_line;
      logic [2:0]  plane_count;
      logic [15:0] row_count;
   } cfg_type;

endpackage

[rtl/pcxrle_front.sv]
// front end: splits the compressed byte stream into literal and run commands
module pcxrle_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_comp_byte,
   input  logic                     queue_full,
   output logic                     push,
   output pcxrle_pkg::run_cmd_type  push_cmd
);
   import pcxrle_pkg::*;

   logic       awaiting_ff, awaiting_in;
   logic [5:0] count_ff, count_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      awaiting_in    = awaiting_ff;
      count_in       = count_ff;
      push           = 1'b0;
      push_cmd.value = req_comp_byte;
      push_cmd.count = 6'd1;
      if (accept) begin
         if (!awaiting_ff) begin
            if (req_comp_byte < RUN_MARK) begin
               push = 1'b1;
            end else begin
               awaiting_in = 1'b1;
               count_in    = req_comp_byte[5:0];
            end
         end else begin
            awaiting_in    = 1'b0;
            push           = (count_ff != 6'd0);
            push_cmd.count = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         count_ff    <= 6'd0;
      end else begin
         awaiting_ff <= awaiting_in;
         count_ff    <= count_in;
      end
   end

endmodule

[rtl/pcxrle_queue.sv]
// short command queue between front end and run expander
module pcxrle_queue #(
   parameter int unsigned DEPTH = pcxrle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pcxrle_pkg::run_cmd_type  push_cmd,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output pcxrle_pkg::run_cmd_type  head
);
   import pcxrle_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [CntWidth-1:0] DepthCount = CntWidth'(DEPTH);
   localparam logic [PtrWidth-1:0] LastPtr    = PtrWidth'(DEPTH - 1);

   run_cmd_type               slot_ff [DEPTH];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]       fill_ff, fill_in;
   logic                      do_push, do_pop;

   assign full    = (fill_ff == DepthCount);
   assign empty   = (fill_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/pcxrle_back.sv]
// back end: expands runs, tracks column, plane and row, holds the output beat
module pcxrle_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pcxrle_pkg::cfg_type      cfg,
   input  logic                     queue_empty,
   input  pcxrle_pkg::run_cmd_type  queue_head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_pixel_byte,
   output logic [1:0]               rsp_plane,
   output logic [15:0]              rsp_column,
   output logic [15:0]              rsp_row,
   output logic                     rsp_last_of_run,
   output logic                     rsp_last_of_image
);
   import pcxrle_pkg::*;

   logic        cmd_valid_ff, cmd_valid_in;
   logic [7:0]  cmd_value_ff, cmd_value_in;
   logic [5:0]  cmd_count_ff, cmd_count_in;
   logic [15:0] column_ff, column_in;
   logic [1:0]  plane_ff, plane_in;
   logic [15:0] row_ff, row_in;
   logic        done_ff, done_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic [1:0]  out_plane_ff;
   logic [15:0] out_column_ff;
   logic [15:0] out_row_ff;
   logic        out_last_run_ff;
   logic        out_last_image_ff;

   logic [15:0] eff_bpl, eff_rows;
   logic [2:0]  eff_planes;
   logic [16:0] column_next;
   logic [2:0]  plane_next;
   logic [16:0] row_next;
   logic        line_wrap, plane_wrap, image_end;
   logic        advance, cmd_free;

   assign eff_bpl    = (cfg.bytes_per_line == 16'd0) ? 16'd1 : cfg.bytes_per_line;
   assign eff_rows   = (cfg.row_count == 16'd0) ? 16'd1 : cfg.row_count;
   assign eff_planes = (cfg.plane_count == 3'd0) ? 3'd1 :
                       (cfg.plane_count > 3'd4) ? 3'd4 : cfg.plane_count;

   assign column_next = {1'b0, column_ff} + 17'd1;
   assign plane_next  = {1'b0, plane_ff} + 3'd1;
   assign row_next    = {1'b0, row_ff} + 17'd1;
   assign line_wrap   = (column_next >= {1'b0, eff_bpl});
   assign plane_wrap  = line_wrap && (plane_next >= eff_planes);
   assign image_end   = plane_wrap && (row_next >= {1'b0, eff_rows});

   assign advance  = cmd_valid_ff && !done_ff && (!out_valid_ff || rsp_ready);
   assign cmd_free = !cmd_valid_ff || done_ff || (advance && cmd_count_ff == 6'd1);
   assign pop      = cmd_free && !queue_empty;

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      cmd_value_in = cmd_value_ff;
      cmd_count_in = cmd_count_ff;
      column_in    = column_ff;
      plane_in     = plane_ff;
      row_in       = row_ff;
      done_in      = done_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = 1'b1;
         cmd_count_in = cmd_count_ff - 6'd1;
         if (!line_wrap) begin
            column_in = column_next[15:0];
         end else begin
            column_in = 16'd0;
            if (!plane_wrap) begin
               plane_in = plane_next[1:0];
            end else begin
               plane_in = 2'd0;
               if (image_end) begin
                  done_in = 1'b1;
               end else begin
                  row_in = row_next[15:0];
               end
            end
         end
      end
      if (cmd_free) begin
         cmd_valid_in = pop;
         cmd_value_in = queue_head.value;
         cmd_count_in = queue_head.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         column_ff    <= 16'd0;
         plane_ff     <= 2'd0;
         row_ff       <= 16'd0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         column_ff    <= column_in;
         plane_ff     <= plane_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_value_ff <= cmd_value_in;
      cmd_count_ff <= cmd_count_in;
      if (advance) begin
         out_byte_ff       <= cmd_value_ff;
         out_plane_ff      <= plane_ff;
         out_column_ff     <= column_ff;
         out_row_ff        <= row_ff;
         out_last_run_ff   <= (cmd_count_ff == 6'd1) || image_end;
         out_last_image_ff <= image_end;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_byte    = out_byte_ff;
   assign rsp_plane         = out_plane_ff;
   assign rsp_column        = out_column_ff;
   assign rsp_row           = out_row_ff;
   assign rsp_last_of_run   = out_last_run_ff;
   assign rsp_last_of_image = out_last_image_ff;

endmodule

[rtl/pcx_rle_scanline_decoder.sv]
// top level of the pcx run-length scanline decoder
//
// Compressed bytes enter on the req_ channel, one byte per beat. A byte
// below 0xC0 is a literal; a byte of 0xC0 or more is a run header whose low
// six bits count how often the next byte repeats. Decoded bytes leave on the
// rsp_ channel tagged with plane, column and row, plus end-of-run and
// end-of-image flags. The csr_ channel writes bytes_per_line, plane_count
// and row_count; it is always ready and should be used only while idle.
// Output beats are registered. While rsp_ready stays high, literals stream
// and runs drain at one byte per cycle through the single run expander; the
// command queue between the parser and the expander absorbs up to
// QUEUE_DEPTH commands before req_ready drops. Headers and zero-length runs
// produce no output. When rsp_ready is low the output beat holds and the
// expander and queue stall in turn. Once the last byte of the image is
// produced, later input is swallowed. Reset clears positions and restores
// the default geometry 320 x 1 x 200.
module pcx_rle_scanline_decoder #(
   parameter int unsigned QUEUE_DEPTH = pcxrle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_comp_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_byte,
   output logic [1:0]  rsp_plane,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_row,
   output logic        rsp_last_of_run,
   output logic        rsp_last_of_image,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import pcxrle_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   run_cmd_type push_cmd;
   run_cmd_type queue_head;
   logic        push, pop, queue_full, queue_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BYTES_PER_LINE: cfg_in.bytes_per_line = csr_wdata;
            CSR_PLANE_COUNT:    cfg_in.plane_count    = csr_wdata[2:0];
            CSR_ROW_COUNT:      cfg_in.row_count      = csr_wdata;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_line <= BYTES_PER_LINE_RESET;
         cfg_ff.plane_count    <= PLANE_COUNT_RESET;
         cfg_ff.row_count      <= ROW_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcxrle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_comp_byte (req_comp_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   pcxrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (queue_head)
   );

   pcxrle_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .queue_empty       (queue_empty),
      .queue_head        (queue_head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_byte    (rsp_pixel_byte),
      .rsp_plane         (rsp_plane),
      .rsp_column        (rsp_column),
      .rsp_row           (rsp_row),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule
